@@ rtl/core/bully_pkg.sv @@
// Package with the types, codes and sizes shared by the bully election node.
`default_nettype none
package bully_pkg;

  localparam int MaxNodes   = 16;
  localparam int TimerBits  = 16;
  localparam int RankW      = 4;
  localparam int CntW       = 5;
  localparam int IdW        = 5;
  localparam int WaitW      = 16;
  localparam int CmpW       = (TimerBits > WaitW) ? TimerBits : WaitW;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);
  localparam int CntLimitI  = (MaxNodes < 16) ? MaxNodes : 16;

  localparam logic [CntW-1:0]      CntLimit = CntW'(CntLimitI);
  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_MSG     = 3'd1,
    CMD_ELECT   = 3'd2,
    CMD_OFFLINE = 3'd3,
    CMD_ONLINE  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    K_ELECTION = 2'd0,
    K_OK       = 2'd1,
    K_COORD    = 2'd2,
    K_NONE     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE       = 2'd0,
    ST_WAIT_OK    = 2'd1,
    ST_WAIT_COORD = 2'd2,
    ST_LEADER     = 2'd3
  } nstate_e;

  typedef enum logic [1:0] {
    REG_MY_RANK    = 2'd0,
    REG_NODE_COUNT = 2'd1,
    REG_OK_WAIT    = 2'd2,
    REG_COORD_WAIT = 2'd3
  } reg_e;

  typedef struct packed {
    logic [RankW-1:0] my_rank;
    logic [CntW-1:0]  node_count;
    logic [WaitW-1:0] ok_wait;
    logic [WaitW-1:0] coord_wait;
  } cfg_t;

  typedef struct packed {
    logic             ok_vld;
    logic [RankW-1:0] ok_dest;
    kind_e            run_kind;
    logic [CntW-1:0]  run_cnt;
    logic [CntW-1:0]  run_first;
    logic [RankW-1:0] skip;
    logic [IdW-1:0]   leader;
    nstate_e          state;
    logic             offline;
  } job_t;

endpackage
`default_nettype wire

@@ rtl/core/bully_cfg.sv @@
// Configuration registers behind the APB-style port.
`default_nettype none
module bully_cfg import bully_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t  cfg_q, cfg_d;
  logic  wr_en;
  reg_e  widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (widx)
        REG_MY_RANK:    cfg_d.my_rank    = pwdata[RankW-1:0];
        REG_NODE_COUNT: cfg_d.node_count = pwdata[CntW-1:0];
        REG_OK_WAIT:    cfg_d.ok_wait    = pwdata[WaitW-1:0];
        REG_COORD_WAIT: cfg_d.coord_wait = pwdata[WaitW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MY_RANK:    prdata = 32'(cfg_q.my_rank);
      REG_NODE_COUNT: prdata = 32'(cfg_q.node_count);
      REG_OK_WAIT:    prdata = 32'(cfg_q.ok_wait);
      REG_COORD_WAIT: prdata = 32'(cfg_q.coord_wait);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.my_rank    <= '0;
      cfg_q.node_count <= CntW'(16);
      cfg_q.ok_wait    <= WaitW'(100);
      cfg_q.coord_wait <= WaitW'(200);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bully_front.sv @@
// Front part: takes each input request, updates the election state and issues a send job.
`default_nettype none
module bully_front import bully_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_vld_i,
  output logic             in_rdy_o,
  input  logic [2:0]       cmd_i,
  input  logic [1:0]       kind_i,
  input  logic [RankW-1:0] src_i,
  input  logic [IdW-1:0]   ann_i,
  input  logic             full_i,
  output logic             push_o,
  output job_t             job_o
);

  nstate_e              state_q, state_d;
  logic                 off_q, off_d;
  logic                 ok_seen_q, ok_seen_d;
  logic [TimerBits-1:0] timer_q, timer_d;
  logic [IdW-1:0]       leader_q, leader_d;

  logic [CntW-1:0]      cnt;
  logic [IdW-1:0]       id_self;
  logic [TimerBits-1:0] tinc;
  logic                 tmo_ok, tmo_coord, higher, self_in;
  logic                 start, ann;
  logic                 acc;

  assign in_rdy_o  = !full_i;
  assign acc       = in_vld_i && !full_i;
  assign push_o    = acc;
  assign cnt       = (cfg_i.node_count > CntLimit) ? CntLimit : cfg_i.node_count;
  assign id_self   = {1'b0, cfg_i.my_rank} + IdW'(1);
  assign tinc      = (timer_q == TimerMax) ? timer_q : timer_q + TimerBits'(1);
  assign tmo_ok    = CmpW'(tinc) >= CmpW'(cfg_i.ok_wait);
  assign tmo_coord = CmpW'(tinc) >= CmpW'(cfg_i.coord_wait);
  assign higher    = CntW'(id_self) < cnt;
  assign self_in   = {1'b0, cfg_i.my_rank} < cnt;

  always_comb begin
    state_d   = state_q;
    off_d     = off_q;
    ok_seen_d = ok_seen_q;
    timer_d   = timer_q;
    leader_d  = leader_q;
    start     = 1'b0;
    ann       = 1'b0;
    job_o.ok_vld    = 1'b0;
    job_o.ok_dest   = src_i;
    job_o.run_kind  = K_NONE;
    job_o.run_cnt   = '0;
    job_o.run_first = '0;
    job_o.skip      = cfg_i.my_rank;

    case (cmd_e'(cmd_i))
      CMD_TICK: begin
        if (!off_q) begin
          timer_d = tinc;
          if (state_q == ST_WAIT_OK && !ok_seen_q && tmo_ok) begin
            ann = 1'b1;
          end else if (state_q == ST_WAIT_COORD && tmo_coord) begin
            start = 1'b1;
          end
        end
      end
      CMD_MSG: begin
        if (!off_q) begin
          case (kind_e'(kind_i))
            K_ELECTION: begin
              job_o.ok_vld = 1'b1;
              if (state_q == ST_IDLE) start = 1'b1;
            end
            K_OK: begin
              ok_seen_d = 1'b1;
              if (state_q == ST_WAIT_OK) begin
                state_d = ST_WAIT_COORD;
                timer_d = '0;
              end
            end
            K_COORD: begin
              leader_d = ann_i;
              state_d  = (ann_i == id_self) ? ST_LEADER : ST_IDLE;
            end
            default: begin
            end
          endcase
        end
      end
      CMD_ELECT: begin
        if (!off_q) start = 1'b1;
      end
      CMD_OFFLINE: begin
        off_d   = 1'b1;
        state_d = ST_IDLE;
      end
      CMD_ONLINE: begin
        if (off_q) begin
          off_d = 1'b0;
          start = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (start) begin
      ok_seen_d = 1'b0;
      timer_d   = '0;
      if (higher) begin
        state_d         = ST_WAIT_OK;
        job_o.run_kind  = K_ELECTION;
        job_o.run_cnt   = cnt - CntW'(id_self);
        job_o.run_first = CntW'(id_self);
      end else begin
        ann = 1'b1;
      end
    end

    if (ann) begin
      leader_d        = id_self;
      state_d         = ST_LEADER;
      job_o.run_kind  = K_COORD;
      job_o.run_cnt   = cnt - CntW'(self_in);
      job_o.run_first = (cfg_i.my_rank == '0) ? CntW'(1) : '0;
    end

    job_o.leader  = leader_d;
    job_o.state   = state_d;
    job_o.offline = off_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      off_q     <= 1'b0;
      ok_seen_q <= 1'b0;
      timer_q   <= '0;
      leader_q  <= '0;
    end else if (acc) begin
      state_q   <= state_d;
      off_q     <= off_d;
      ok_seen_q <= ok_seen_d;
      timer_q   <= timer_d;
      leader_q  <= leader_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bully_fifo.sv @@
// Short job queue between the front and the back part.
`default_nettype none
module bully_fifo import bully_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic vld_o,
  output job_t data_o
);

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign vld_o   = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth))
    else $error("job queue count exceeds its depth");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && !full_o) |=> cnt_q == $past(cnt_q) + QCntW'(1))
    else $error("job queue count did not grow on a lone push");

endmodule
`default_nettype wire

@@ rtl/core/bully_back.sv @@
// Back part: expands each send job into result items, one per cycle unless the output stalls.
`default_nettype none
module bully_back import bully_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_vld_i,
  input  job_t        q_data_i,
  output logic        pop_o,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  job_t             job_q, job_d;
  logic             act_q, act_d;
  logic             okp_q, okp_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  idx_inc, idx_nxt;

  logic             ovld_q, ovld_d;
  kind_e            okind_q, okind_d;
  logic [RankW-1:0] odest_q, odest_d;
  logic             olast_q, olast_d;
  logic [IdW-1:0]   olead_q;
  nstate_e          ostate_q;
  logic             ooff_q;

  logic             advance, emit;

  assign advance = !ovld_q || m_tready;
  assign emit    = act_q && advance;
  assign pop_o   = !act_q && q_vld_i;
  assign idx_inc = idx_q + CntW'(1);
  assign idx_nxt = (idx_inc == {1'b0, job_q.skip}) ? idx_q + CntW'(2) : idx_inc;

  always_comb begin
    job_d   = job_q;
    act_d   = act_q;
    okp_d   = okp_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    ovld_d  = ovld_q && !m_tready;
    okind_d = okind_q;
    odest_d = odest_q;
    olast_d = olast_q;
    if (pop_o) begin
      job_d = q_data_i;
      act_d = 1'b1;
      okp_d = q_data_i.ok_vld;
      rem_d = q_data_i.run_cnt;
      idx_d = q_data_i.run_first;
    end else if (emit) begin
      ovld_d = 1'b1;
      if (okp_q) begin
        okind_d = K_OK;
        odest_d = job_q.ok_dest;
        olast_d = rem_q == '0;
        okp_d   = 1'b0;
        act_d   = rem_q != '0;
      end else if (rem_q != '0) begin
        okind_d = job_q.run_kind;
        odest_d = idx_q[RankW-1:0];
        olast_d = rem_q == CntW'(1);
        rem_d   = rem_q - CntW'(1);
        idx_d   = idx_nxt;
        act_d   = rem_q != CntW'(1);
      end else begin
        okind_d = K_NONE;
        odest_d = '0;
        olast_d = 1'b1;
        act_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    okp_q   <= okp_d;
    rem_q   <= rem_d;
    idx_q   <= idx_d;
    okind_q <= okind_d;
    odest_q <= odest_d;
    olast_q <= olast_d;
    if (emit) begin
      olead_q  <= job_q.leader;
      ostate_q <= job_q.state;
      ooff_q   <= job_q.offline;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      act_q  <= act_d;
      ovld_q <= ovld_d;
    end
  end

  assign m_tvalid = ovld_q;
  assign m_tuser  = okind_q;
  assign m_tlast  = olast_q;
  assign m_tdata  = {4'b0000, ooff_q, ostate_q, olead_q, odest_q};

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && olast_d) |=> !act_q)
    else $error("job still active after its final result");

  a_idx_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q && !okp_q && rem_q != '0) |->
      (idx_q != {1'b0, job_q.skip}) && (idx_q[CntW-1] == 1'b0))
    else $error("destination index hits own rank or leaves the rank range");

endmodule
`default_nettype wire

@@ rtl/core/bully_leader_election_node_top.sv @@
// Top level of one bully leader election node: config port, front part, job queue, back part.
// An input request's first result passes the job queue, the back part's job register and
// the output register. An input causing k results (1 to 16) occupies the sender for a load
// step, then a result per cycle unless m_tready stalls; the queue holds two pending inputs.
// Input requests are taken one per cycle while the job queue has room.
// Reset clears the election state, the queue and the output, and loads the registers
// with rank 0, 16 nodes, 100 and 200 ticks; no clearing pass is needed.
`default_nettype none
module bully_leader_election_node_top import bully_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // source_rank [3:0], announced_id [8:4], zeros above
  input  logic [4:0]  s_tuser,   // cmd [2:0], msg_kind [4:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // dest_rank, leader_id, node_state, is_offline, zeros
  output logic [1:0]  m_tuser,   // send_kind [1:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  job_t job_in, job_out;
  logic push, full, pop, q_vld;

  bully_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bully_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_vld_i (s_tvalid),
    .in_rdy_o (s_tready),
    .cmd_i    (s_tuser[2:0]),
    .kind_i   (s_tuser[4:3]),
    .src_i    (s_tdata[3:0]),
    .ann_i    (s_tdata[8:4]),
    .full_i   (full),
    .push_o   (push),
    .job_o    (job_in)
  );

  bully_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .vld_o  (q_vld),
    .data_o (job_out)
  );

  bully_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_vld_i  (q_vld),
    .q_data_i (job_out),
    .pop_o    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
